### rtl/core/ffba_pkg.sv
// Shared types and constants for the first-fit bucket allocator.
// Depends on nothing; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package ffba_pkg;

  localparam int SLOT_W  = 6;
  localparam int COUNT_W = 7;
  localparam int CMD_W   = 2;
  localparam int CODE_W  = 3;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_REGISTER = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REQUEST  = 2'd2;

  // Result codes.
  localparam logic [CODE_W-1:0] RC_GRANT = 3'd0;
  localparam logic [CODE_W-1:0] RC_EMPTY = 3'd1;
  localparam logic [CODE_W-1:0] RC_SHORT = 3'd2;
  localparam logic [CODE_W-1:0] RC_RANGE = 3'd3;
  localparam logic [CODE_W-1:0] RC_ACK   = 3'd4;

  localparam logic [COUNT_W-1:0] REG_COUNT_MAX = 7'd127;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [SLOT_W-1:0]  slot_index;
    logic [COUNT_W-1:0] request_count;
  } item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] granted_slot;
    logic [CODE_W-1:0] result_code;
    logic              pool_ready;
    logic              last;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the incoming item
    logic single;     // execute a one-result command
    logic scan_init;  // prepare a first-fit scan
    logic scan_step;  // examine one slot of the scan
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic grant_ok;    // held item is a request that will succeed
    logic scan_final;  // the current scan step grants the last slot
  } dp_status_t;

endpackage

### rtl/core/first_fit_bucket_allocator_unit.sv
// Top level of the first-fit bucket allocator: controller plus datapath.
// Depends on ffba_pkg, ffba_ctrl and ffba_datapath.
//
//   Channel   Ports                 Transfer takes place when
//   -------   -------------------   ------------------------------------------
//   command   start, busy, item     rising edge with start high and busy low
//   result    done, result          rising edge that ends the cycle done is high
//
// Every command is latched on acceptance and decided in the following cycle.
// Register, free, rejected requests and unknown commands give one result and
// then end. A successful request for k slots walks the slot table one slot
// per cycle from slot 0 until its k-th idle slot is granted, so it walks at
// most POOL_SIZE slots. Grants appear in ascending slot order, one per idle
// slot met, the last one flagged.
// Reset (rst, synchronous, active high) marks every slot not registered and
// clears the registration count and the ready flag. The receiver cannot stall:
// each result is marked by done, which is high for a single cycle.
`timescale 1ns / 1ps

module first_fit_bucket_allocator_unit #(
  parameter int POOL_SIZE = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  ffba_pkg::item_t     item,
  output logic                done,
  output ffba_pkg::result_t   result
);
  import ffba_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // The controller only sequences; all allocation state lives in the datapath.
  ffba_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // The datapath holds the idle map and counters and registers each result,
  // so that a new command may be accepted while the last result is shown.
  ffba_datapath #(
    .POOL_SIZE (POOL_SIZE)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .status (status),
    .result (result),
    .done   (done)
  );

endmodule

### rtl/core/ffba_ctrl.sv
// Sequencing state machine of the first-fit bucket allocator.
// Depends on ffba_pkg for the command and status structs.
`timescale 1ns / 1ps

module ffba_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  ffba_pkg::dp_status_t  status,
  output ffba_pkg::ctrl_cmd_t   cmd,
  output logic                  busy
);
  import ffba_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        state_next = status.grant_ok ? S_SCAN : S_IDLE;
      end
      S_SCAN: begin
        if (status.scan_final) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.load      = (state == S_IDLE) && start;
    cmd.single    = (state == S_DECIDE) && !status.grant_ok;
    cmd.scan_init = (state == S_DECIDE) && status.grant_ok;
    cmd.scan_step = (state == S_SCAN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

### rtl/core/ffba_datapath.sv
// Slot table, counters, scan pointer and result register of the allocator.
// Depends on ffba_pkg; driven by ffba_ctrl through command and status structs.
`timescale 1ns / 1ps

module ffba_datapath #(
  parameter int POOL_SIZE = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ffba_pkg::item_t       item,
  input  ffba_pkg::ctrl_cmd_t   cmd,
  output ffba_pkg::dp_status_t  status,
  output ffba_pkg::result_t     result,
  output logic                  done
);
  import ffba_pkg::*;

  localparam int IDX_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int CNT_W = $clog2(POOL_SIZE + 1);
  localparam logic [COUNT_W-1:0] POOL_SIZE_C = COUNT_W'(POOL_SIZE);
  localparam logic [CNT_W-1:0]   POOL_FULL   = CNT_W'(POOL_SIZE);

  // Only the idle state matters to allocation: not registered and busy behave alike.
  logic [POOL_SIZE-1:0] idle_vec;
  logic [POOL_SIZE-1:0] idle_vec_next;
  logic [CNT_W-1:0]     idle_count;
  logic [CNT_W-1:0]     idle_count_next;
  logic [COUNT_W-1:0]   reg_count;
  logic [COUNT_W-1:0]   reg_count_next;
  logic                 ready;
  logic                 ready_next;

  item_t                held;
  logic [IDX_W-1:0]     scan_idx;
  logic [CNT_W-1:0]     remaining;

  result_t              result_next;
  logic                 done_next;

  logic                 in_range;
  logic [IDX_W-1:0]     held_idx;
  logic                 scan_hit;

  assign in_range = ({1'b0, held.slot_index} < POOL_SIZE_C);
  assign held_idx = held.slot_index[IDX_W-1:0];
  assign scan_hit = idle_vec[scan_idx];

  assign status.grant_ok   = (held.command == CMD_REQUEST) &&
                             (held.request_count != '0) &&
                             (held.request_count <= POOL_SIZE_C) &&
                             (held.request_count <= COUNT_W'(idle_count));
  assign status.scan_final = scan_hit && (remaining == CNT_W'(1));

  always_comb begin
    idle_vec_next   = idle_vec;
    idle_count_next = idle_count;
    reg_count_next  = reg_count;
    ready_next      = ready;
    result_next     = result;
    done_next       = 1'b0;

    if (cmd.single) begin
      result_next.granted_slot = '0;
      result_next.last         = 1'b1;
      result_next.result_code  = RC_RANGE;
      done_next                = 1'b1;
      unique case (held.command)
        CMD_REGISTER: begin
          if (in_range) begin
            result_next.result_code = RC_ACK;
            if (reg_count != REG_COUNT_MAX) reg_count_next = reg_count + 1'b1;
            if (reg_count_next == POOL_SIZE_C) begin
              idle_vec_next   = '1;
              idle_count_next = POOL_FULL;
              ready_next      = 1'b1;
            end else if (idle_vec[held_idx]) begin
              idle_vec_next[held_idx] = 1'b0;
              idle_count_next         = idle_count - 1'b1;
            end
          end
        end
        CMD_FREE: begin
          if (in_range) begin
            result_next.result_code = RC_ACK;
            if (!idle_vec[held_idx]) begin
              idle_vec_next[held_idx] = 1'b1;
              idle_count_next         = idle_count + 1'b1;
            end
          end
        end
        CMD_REQUEST: begin
          result_next.result_code = (held.request_count == '0) ? RC_EMPTY : RC_SHORT;
        end
        default: result_next.result_code = RC_RANGE;
      endcase
      result_next.pool_ready = ready_next;
    end else if (cmd.scan_step && scan_hit) begin
      idle_vec_next[scan_idx]  = 1'b0;
      idle_count_next          = idle_count - 1'b1;
      result_next.granted_slot = SLOT_W'(scan_idx);
      result_next.result_code  = RC_GRANT;
      result_next.pool_ready   = ready;
      result_next.last         = (remaining == CNT_W'(1));
      done_next                = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_vec   <= '0;
      idle_count <= '0;
      reg_count  <= '0;
      ready      <= 1'b0;
      done       <= 1'b0;
    end else begin
      idle_vec   <= idle_vec_next;
      idle_count <= idle_count_next;
      reg_count  <= reg_count_next;
      ready      <= ready_next;
      done       <= done_next;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    result <= result_next;
    if (cmd.load) held <= item;
    if (cmd.scan_init) begin
      scan_idx  <= '0;
      remaining <= held.request_count[CNT_W-1:0];
    end else if (cmd.scan_step) begin
      scan_idx <= scan_idx + 1'b1;
      if (scan_hit) remaining <= remaining - 1'b1;
    end
  end

endmodule
